/* rtl/core/a64enc_pkg.sv */
// ----------------------------------------------------------------------------
// a64enc_pkg: shared definitions for the AArch64 instruction encoder
// Instruction form codes, status codes and fixed opcode patterns.
// ----------------------------------------------------------------------------
package a64enc_pkg;

	typedef logic [4:0]  cmd_t;
	typedef logic [1:0]  status_t;
	typedef logic [31:0] insn_t;

	// instruction forms
	localparam cmd_t CMD_NOP   = 5'd0;
	localparam cmd_t CMD_RET   = 5'd1;
	localparam cmd_t CMD_BRK   = 5'd2;
	localparam cmd_t CMD_SVC   = 5'd3;
	localparam cmd_t CMD_BR    = 5'd4;
	localparam cmd_t CMD_BLR   = 5'd5;
	localparam cmd_t CMD_B     = 5'd6;
	localparam cmd_t CMD_BL    = 5'd7;
	localparam cmd_t CMD_BCOND = 5'd8;
	localparam cmd_t CMD_CBZ   = 5'd9;
	localparam cmd_t CMD_CBNZ  = 5'd10;
	localparam cmd_t CMD_MOV   = 5'd11;
	localparam cmd_t CMD_MOVZ  = 5'd12;
	localparam cmd_t CMD_MOVK  = 5'd13;
	localparam cmd_t CMD_MOVN  = 5'd14;
	localparam cmd_t CMD_ADD   = 5'd15;
	localparam cmd_t CMD_SUB   = 5'd16;
	localparam cmd_t CMD_CMP   = 5'd17;
	localparam cmd_t CMD_LDST  = 5'd18;
	localparam cmd_t CMD_WORD  = 5'd19;

	// result status
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_RANGE = 2'd1;
	localparam status_t ST_NEG   = 2'd2;
	localparam status_t ST_LDST  = 2'd3;

	// fixed opcode patterns
	localparam insn_t OP_NOP      = 32'hD503201F;
	localparam insn_t OP_RET      = 32'hD65F03C0;
	localparam insn_t OP_BRK      = 32'hD4200000;
	localparam insn_t OP_SVC      = 32'hD4000001;
	localparam insn_t OP_BR       = 32'hD61F0000;
	localparam insn_t OP_BLR      = 32'hD63F0000;
	localparam insn_t OP_B        = 32'h14000000;
	localparam insn_t OP_BL       = 32'h94000000;
	localparam insn_t OP_BCOND    = 32'h54000000;
	localparam insn_t OP_CBZ      = 32'h34000000;
	localparam insn_t OP_CBNZ     = 32'h35000000;
	localparam insn_t OP_MOVZ     = 32'h52800000;
	localparam insn_t OP_MOVK     = 32'h72800000;
	localparam insn_t OP_MOVN     = 32'h12800000;
	localparam insn_t OP_MOV_REG  = 32'h2A0003E0;
	localparam insn_t OP_ADD_REG  = 32'h0B000000;
	localparam insn_t OP_SUB_REG  = 32'h4B000000;
	localparam insn_t OP_ADD_IMM  = 32'h11000000;
	localparam insn_t OP_SUB_IMM  = 32'h51000000;
	localparam insn_t OP_CMP_REG  = 32'h6B00001F;
	localparam insn_t OP_CMP_IMM  = 32'h71000000;
	localparam insn_t OP_LDST     = 32'h39000000;

endpackage

/* rtl/core/arm64_instruction_encoder_unit.sv */
// ----------------------------------------------------------------------------
// arm64_instruction_encoder_unit: AArch64 instruction word encoder
// Packs one pre-parsed instruction into a 32-bit word and reports a status.
// ----------------------------------------------------------------------------
//
//  channel  handshake               payload
//  -------  ----------------------  ---------------------------------------
//  in       in_valid / in_ready     cmd use_reg reg_d reg_n reg_m wide cond
//                                   shift_quarter imm pc load access_width
//  out      out_valid / out_ready   word status
//
//  One request per cycle sustained while out_ready stays high. A request is
//  captured in the input register (_s1), encoded by one pass of field packing
//  and range checks, and registered into the result register (_s2).
//  The only wide arithmetic is a 28-bit target minus pc subtract.
//  Reset clears both valid bits; payload registers are not reset.
//  When out_ready is low the result holds, the input stage fills behind it,
//  and in_ready drops only once both stages are occupied.
//
module arm64_instruction_encoder_unit
	import a64enc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic [4:0]         cmd,
	input  logic               use_reg,
	input  logic [4:0]         reg_d,
	input  logic [4:0]         reg_n,
	input  logic [4:0]         reg_m,
	input  logic               wide,
	input  logic [3:0]         cond,
	input  logic [1:0]         shift_quarter,
	input  logic signed [63:0] imm,
	input  logic [63:0]        pc,
	input  logic               load,
	input  logic [1:0]         access_width,

	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        word,
	output logic [1:0]         status
);

	// input stage
	logic        v_s1;
	cmd_t        cmd_s1;
	logic        use_reg_s1;
	logic [4:0]  rd_s1;
	logic [4:0]  rn_s1;
	logic [4:0]  rm_s1;
	logic        wide_s1;
	logic [3:0]  cond_s1;
	logic [1:0]  hw_s1;
	logic [63:0] imm_s1;
	logic [27:0] pc_s1;
	logic        load_s1;
	logic [1:0]  aw_s1;

	// result stage
	logic        v_s2;
	insn_t       word_s2;
	status_t     status_s2;

	logic        adv_s1;
	logic        take_in;

	// encoder pass
	insn_t       enc_word;
	status_t     enc_st;
	insn_t       wbit;
	logic [27:0] diff;
	logic [25:0] off;
	logic [21:0] arith_fld;
	status_t     arith_st;
	logic [1:0]  scale;
	logic [11:0] ldst_fld;
	logic        ldst_bad;

	// result register moves when empty or when its result is taken
	assign adv_s1   = !v_s2 || out_ready;
	assign in_ready = !v_s1 || adv_s1;
	assign take_in  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			cmd_s1     <= cmd;
			use_reg_s1 <= use_reg;
			rd_s1      <= reg_d;
			rn_s1      <= reg_n;
			rm_s1      <= reg_m;
			wide_s1    <= wide;
			cond_s1    <= cond;
			hw_s1      <= shift_quarter;
			imm_s1     <= imm;
			// branch offsets only ever use bits 27:2 of the difference
			pc_s1      <= pc[27:0];
			load_s1    <= load;
			aw_s1      <= access_width;
		end
	end

	// branch offset, word aligned, wrapped to the widest field
	assign diff = imm_s1[27:0] - pc_s1;
	assign off  = diff[27:2];
	assign wbit = {wide_s1, 31'd0};

	// 12-bit arithmetic immediate, plain or shifted by twelve
	always_comb begin
		arith_fld = '0;
		arith_st  = ST_RANGE;
		if (imm_s1[63]) begin
			arith_st = ST_NEG;
		end else if (imm_s1[63:12] == '0) begin
			arith_st  = ST_OK;
			arith_fld = {10'd0, imm_s1[11:0]};
		end else if (imm_s1[11:0] == '0 && imm_s1[63:24] == '0) begin
			// shift flag lands on bit 22 of the word
			arith_st  = ST_OK;
			arith_fld = {9'd0, 1'b1, imm_s1[23:12]};
		end
	end

	// load/store scaled offset: size from access width, register width by wide
	always_comb begin
		scale = (aw_s1 == 2'd0) ? 2'd0 :
			(aw_s1 == 2'd1) ? 2'd1 : {1'b1, wide_s1};
		case (scale)
			2'd0: begin
				ldst_bad = imm_s1[63:12] != '0;
				ldst_fld = imm_s1[11:0];
			end
			2'd1: begin
				ldst_bad = imm_s1[0] || imm_s1[63:13] != '0;
				ldst_fld = imm_s1[12:1];
			end
			2'd2: begin
				ldst_bad = imm_s1[1:0] != '0 || imm_s1[63:14] != '0;
				ldst_fld = imm_s1[13:2];
			end
			default: begin
				ldst_bad = imm_s1[2:0] != '0 || imm_s1[63:15] != '0;
				ldst_fld = imm_s1[14:3];
			end
		endcase
	end

	// main form decode
	always_comb begin
		enc_word = '0;
		enc_st   = ST_OK;
		case (cmd_s1)
			CMD_NOP: enc_word = OP_NOP;
			CMD_RET: enc_word = OP_RET;
			CMD_BRK: enc_word = OP_BRK | {11'd0, imm_s1[15:0], 5'd0};
			CMD_SVC: enc_word = OP_SVC | {11'd0, imm_s1[15:0], 5'd0};
			CMD_BR:  enc_word = OP_BR  | {22'd0, rn_s1, 5'd0};
			CMD_BLR: enc_word = OP_BLR | {22'd0, rn_s1, 5'd0};
			CMD_B:   enc_word = OP_B   | {6'd0, off};
			CMD_BL:  enc_word = OP_BL  | {6'd0, off};
			CMD_BCOND: begin
				enc_word = OP_BCOND | {8'd0, off[18:0], 1'b0, cond_s1};
			end
			CMD_CBZ, CMD_CBNZ: begin
				enc_word = ((cmd_s1 == CMD_CBNZ) ? OP_CBNZ : OP_CBZ) | wbit |
					{8'd0, off[18:0], rd_s1};
			end
			CMD_MOV, CMD_MOVZ, CMD_MOVK, CMD_MOVN: begin
				if (cmd_s1 == CMD_MOV && use_reg_s1) begin
					enc_word = OP_MOV_REG | wbit | {11'd0, rm_s1, 11'd0, rd_s1};
				end else if (imm_s1[63]) begin
					enc_st = ST_NEG;
				end else if (imm_s1[63:16] != '0 &&
					!(cmd_s1 == CMD_MOV && imm_s1[63:32] == '0)) begin
					enc_st = ST_RANGE;
				end else begin
					// mov of a 32-bit value keeps only its low half
					enc_word = ((cmd_s1 == CMD_MOVK) ? OP_MOVK :
						(cmd_s1 == CMD_MOVN) ? OP_MOVN : OP_MOVZ) | wbit |
						{9'd0, hw_s1, imm_s1[15:0], rd_s1};
				end
			end
			CMD_ADD, CMD_SUB: begin
				if (use_reg_s1) begin
					enc_word = ((cmd_s1 == CMD_SUB) ? OP_SUB_REG : OP_ADD_REG) |
						wbit | {11'd0, rm_s1, 6'd0, rn_s1, rd_s1};
				end else begin
					enc_st   = arith_st;
					enc_word = ((cmd_s1 == CMD_SUB) ? OP_SUB_IMM : OP_ADD_IMM) |
						wbit | {arith_fld, rn_s1, rd_s1};
				end
			end
			CMD_CMP: begin
				if (use_reg_s1) begin
					enc_word = OP_CMP_REG | wbit | {11'd0, rm_s1, 6'd0, rn_s1, 5'd0};
				end else begin
					enc_st   = arith_st;
					enc_word = OP_CMP_IMM | wbit | {arith_fld, rn_s1, 5'd31};
				end
			end
			CMD_LDST: begin
				if (ldst_bad) begin
					enc_st = ST_LDST;
				end else begin
					enc_word = OP_LDST | {scale, 7'd0, load_s1, ldst_fld, rn_s1, rd_s1};
				end
			end
			CMD_WORD: enc_word = imm_s1[31:0];
			default:  enc_st   = ST_RANGE;
		endcase
		// drop the word on any error
		if (enc_st != ST_OK) begin
			enc_word = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s1) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && v_s1) begin
			word_s2   <= enc_word;
			status_s2 <= enc_st;
		end
	end

	assign out_valid = v_s2;
	assign word      = word_s2;
	assign status    = status_s2;

	// an error result never carries a word
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> word == '0)
		else $error("error result with nonzero word");

	// an accepted request always lands in the input stage
	a_take_fill: assert property (@(posedge clk) disable iff (!arst_n)
		take_in |=> v_s1)
		else $error("accepted request lost");

	// a stalled input stage keeps its request
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv_s1 |=> v_s1 && $stable(cmd_s1) && $stable(imm_s1))
		else $error("input stage dropped a stalled request");

	// input stage advances into the result register
	a_s2_fill: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv_s1 |=> out_valid)
		else $error("result stage missed a request");

	// backpressure only when both stages are full and the result is stalled
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && out_valid && !out_ready)
		else $error("in_ready low without a full stall");

endmodule

/* dv/a64enc_word_monitor.sv */
// ----------------------------------------------------------------------------
// a64enc_word_monitor: result tracking for the AArch64 instruction encoder
// Watches both channels of the encoder, works out the word and status that
// each accepted request must produce, and compares them in order with the
// results the block hands out. Reports failures as a running count.
// ----------------------------------------------------------------------------
module a64enc_word_monitor
	import a64enc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [4:0]         cmd,
	input  logic               use_reg,
	input  logic [4:0]         reg_d,
	input  logic [4:0]         reg_n,
	input  logic [4:0]         reg_m,
	input  logic               wide,
	input  logic [3:0]         cond,
	input  logic [1:0]         shift_quarter,
	input  logic signed [63:0] imm,
	input  logic [63:0]        pc,
	input  logic               load,
	input  logic [1:0]         access_width,

	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [31:0]        word,
	input  logic [1:0]         status,

	output int                 fail_count,
	output int                 pending,
	output int                 results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] AW_BYTE = 2'd0;
	localparam logic [1:0] AW_HALF = 2'd1;

	typedef struct packed {
		insn_t   word;
		status_t status;
	} enc_result_t;

	enc_result_t expected_words[$];
	int errs;
	int seen;

	// 12-bit add/sub immediate, optionally shifted by twelve
	function automatic status_t pack_arith_imm(logic [63:0] v, output logic [31:0] fld);
		fld = '0;
		if (v[63])
			return ST_NEG;
		if (v <= 64'hFFF) begin
			fld = 32'(v) << 10;
			return ST_OK;
		end
		if (v[11:0] == 12'h000 && (v >> 12) <= 64'hFFF) begin
			fld = 32'h0040_0000 | (32'(v >> 12) << 10);
			return ST_OK;
		end
		return ST_RANGE;
	endfunction

	function automatic enc_result_t encode_insn(cmd_t c, logic ureg, logic [4:0] rd,
			logic [4:0] rn, logic [4:0] rm, logic wd, logic [3:0] cc, logic [1:0] hw,
			logic [63:0] iv, logic [63:0] pcv, logic ld, logic [1:0] aw);
		enc_result_t r;
		logic [63:0] disp;
		logic [63:0] val;
		logic [63:0] align;
		logic [31:0] sf;
		logic [31:0] fld;
		logic [31:0] base;
		int unsigned sc;
		r.word   = '0;
		r.status = ST_OK;
		disp = (iv - pcv) >> 2;
		sf   = wd ? 32'h8000_0000 : 32'h0;
		val  = iv;
		fld  = '0;
		case (c)
			CMD_NOP:   r.word = OP_NOP;
			CMD_RET:   r.word = OP_RET;
			CMD_BRK:   r.word = OP_BRK | (32'(iv[15:0]) << 5);
			CMD_SVC:   r.word = OP_SVC | (32'(iv[15:0]) << 5);
			CMD_BR:    r.word = OP_BR | (32'(rn) << 5);
			CMD_BLR:   r.word = OP_BLR | (32'(rn) << 5);
			CMD_B:     r.word = OP_B | 32'(disp[25:0]);
			CMD_BL:    r.word = OP_BL | 32'(disp[25:0]);
			CMD_BCOND: r.word = OP_BCOND | (32'(disp[18:0]) << 5) | 32'(cc);
			CMD_CBZ, CMD_CBNZ:
				r.word = ((c == CMD_CBNZ) ? OP_CBNZ : OP_CBZ) | sf |
					(32'(disp[18:0]) << 5) | 32'(rd);
			CMD_MOV, CMD_MOVZ, CMD_MOVK, CMD_MOVN: begin
				if (c == CMD_MOV && ureg) begin
					r.word = OP_MOV_REG | (32'(rm) << 16) | 32'(rd) | sf;
				end else if (iv[63]) begin
					r.status = ST_NEG;
				end else if (iv > 64'hFFFF && !(c == CMD_MOV && iv <= 64'hFFFF_FFFF)) begin
					r.status = ST_RANGE;
				end else begin
					// plain mov keeps only the low halfword of a 32-bit value
					val  = iv & 64'hFFFF;
					base = (c == CMD_MOVK) ? OP_MOVK : (c == CMD_MOVN) ? OP_MOVN : OP_MOVZ;
					r.word = base | sf | (32'(hw) << 21) | (32'(val[15:0]) << 5) | 32'(rd);
				end
			end
			CMD_ADD, CMD_SUB: begin
				if (ureg) begin
					r.word = ((c == CMD_SUB) ? OP_SUB_REG : OP_ADD_REG) | sf |
						(32'(rm) << 16) | (32'(rn) << 5) | 32'(rd);
				end else begin
					r.status = pack_arith_imm(iv, fld);
					r.word = ((c == CMD_SUB) ? OP_SUB_IMM : OP_ADD_IMM) | sf | fld |
						(32'(rn) << 5) | 32'(rd);
				end
			end
			CMD_CMP: begin
				if (ureg) begin
					r.word = OP_CMP_REG | sf | (32'(rm) << 16) | (32'(rn) << 5);
				end else begin
					r.status = pack_arith_imm(iv, fld);
					r.word = OP_CMP_IMM | sf | fld | (32'(rn) << 5) | 32'd31;
				end
			end
			CMD_LDST: begin
				case (aw)
					AW_BYTE: sc = 0;
					AW_HALF: sc = 1;
					default: sc = wd ? 3 : 2;
				endcase
				align = (64'd1 << sc) - 64'd1;
				if (iv[63] || (iv & align) != 64'd0 || (iv >> sc) > 64'hFFF)
					r.status = ST_LDST;
				else
					r.word = OP_LDST | (32'(sc) << 30) | (ld ? 32'h0040_0000 : 32'h0) |
						(32'(iv >> sc) << 10) | (32'(rn) << 5) | 32'(rd);
			end
			CMD_WORD:  r.word = iv[31:0];
			default:   r.status = ST_RANGE;
		endcase
		if (r.status != ST_OK)
			r.word = '0;
		return r;
	endfunction

	initial begin
		errs = 0;
		seen = 0;
		fail_count = 0;
		pending = 0;
		results_seen = 0;
	end

	always @(posedge clk) begin
		enc_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_words.insert(expected_words.size(), encode_insn(cmd, use_reg,
					reg_d, reg_n, reg_m, wide, cond, shift_quarter, imm, pc, load,
					access_width));
			if (out_valid && out_ready) begin
				seen++;
				if (expected_words.size() == 0) begin
					$display("%0t ns: result with no request pending, expected none, actual %h/%0d",
						$time, word, status);
					errs++;
				end else begin
					want = expected_words.pop_front();
					if (word !== want.word) begin
						$display("%0t ns: word mismatch, expected %h, actual %h",
							$time, want.word, word);
						errs++;
					end
					if (status !== want.status) begin
						$display("%0t ns: status mismatch, expected %0d, actual %0d",
							$time, want.status, status);
						errs++;
					end
				end
			end
		end
		fail_count   <= errs;
		pending      <= expected_words.size();
		results_seen <= seen;
	end

endmodule

/* dv/tb_arm64_instruction_encoder_unit.sv */
// ----------------------------------------------------------------------------
// tb_arm64_instruction_encoder_unit: testbench for the AArch64 encoder
// Drives a directed set of instructions covering every form, field extreme
// and error path, then a long run of random instructions shaped per form.
// Both channels idle at random; a word monitor predicts and compares.
// ----------------------------------------------------------------------------
module tb_arm64_instruction_encoder_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import a64enc_pkg::*;

	localparam int   RANDOM_ITEMS = 2000;
	localparam int   DRAIN_ITEMS  = 200;   // final stretch with both sides always ready
	localparam int   IDLE_LIMIT   = 2000;  // cycles without any handshake before giving up
	localparam int   TAIL_CYCLES  = 8;     // leave room for stray results
	localparam int   HOLD_CYCLES  = 96;    // long receiver hold-off to fill the pipeline
	localparam cmd_t CMD_TOP_CODE = 5'd31; // highest code on the port, not a valid form

	localparam logic [1:0] AW_BYTE = 2'd0;
	localparam logic [1:0] AW_HALF = 2'd1;
	localparam logic [1:0] AW_REG  = 2'd2;
	localparam logic [1:0] AW_ALT  = 2'd3; // behaves as register width

	typedef struct {
		cmd_t        cmd;
		logic        use_reg;
		logic [4:0]  rd;
		logic [4:0]  rn;
		logic [4:0]  rm;
		logic        wd;
		logic [3:0]  cc;
		logic [1:0]  hw;
		logic [63:0] iv;
		logic [63:0] pcv;
		logic        ld;
		logic [1:0]  aw;
	} insn_req_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [4:0]         cmd;
	logic               use_reg;
	logic [4:0]         reg_d;
	logic [4:0]         reg_n;
	logic [4:0]         reg_m;
	logic               wide;
	logic [3:0]         cond;
	logic [1:0]         shift_quarter;
	logic signed [63:0] imm;
	logic [63:0]        pc;
	logic               load;
	logic [1:0]         access_width;
	logic               out_valid;
	logic               out_ready;
	logic [31:0]        word;
	logic [1:0]         status;

	int fail_count;
	int pending;
	int results_seen;

	// stimulus knobs; drain_phase is shared with the receiver process
	bit          drain_phase;
	int unsigned gap_odds;
	int unsigned requests_sent;

	arm64_instruction_encoder_unit dut (.*);

	a64enc_word_monitor u_words (.*);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Build an instruction with every field random, then bias the immediate
	// toward the boundaries that matter for the chosen form.
	function automatic insn_req_t random_insn();
		insn_req_t r;
		int unsigned pick;
		int unsigned sc;
		logic signed [63:0] delta;
		// a few percent of codes fall outside the defined forms
		if ($urandom_range(0, 24) == 0)
			r.cmd = cmd_t'($urandom_range(CMD_WORD + 1, CMD_TOP_CODE));
		else
			r.cmd = cmd_t'($urandom_range(CMD_NOP, CMD_WORD));
		r.use_reg = 1'($urandom);
		r.rd  = 5'($urandom);
		r.rn  = 5'($urandom);
		r.rm  = 5'($urandom);
		r.wd  = 1'($urandom);
		r.cc  = 4'($urandom);
		r.hw  = 2'($urandom);
		r.ld  = 1'($urandom);
		r.aw  = 2'($urandom);
		r.pcv = {$urandom, $urandom};
		r.iv  = {$urandom, $urandom};
		pick  = $urandom_range(0, 9);
		// signed branch distance of random magnitude, both directions
		delta = $signed({$urandom, $urandom}) >>> $urandom_range(34, 62);
		case (r.cmd)
			CMD_B, CMD_BL, CMD_BCOND, CMD_CBZ, CMD_CBNZ: begin
				if (pick < 8)
					r.iv = r.pcv + delta;
			end
			CMD_MOV, CMD_MOVZ, CMD_MOVK, CMD_MOVN: begin
				case (pick)
					0, 1, 2, 3: r.iv = 64'($urandom_range(0, 16'hFFFF));
					4:          r.iv = 64'($urandom);
					5:          r.iv = 64'h0000_FFFF + 64'($urandom_range(0, 1));
					6:          r.iv = 64'hFFFF_FFFF + 64'($urandom_range(0, 1));
					7:          r.iv = -64'($urandom_range(1, 16'hFFFF));
					default: ;
				endcase
			end
			CMD_ADD, CMD_SUB, CMD_CMP: begin
				case (pick)
					0, 1, 2: r.iv = 64'($urandom_range(0, 12'hFFF));
					3, 4:    r.iv = 64'($urandom_range(0, 12'hFFF)) << 12;
					5:       r.iv = (64'($urandom_range(0, 12'hFFF)) << 12) +
							64'($urandom_range(1, 12'hFFF));
					6: begin
						case ($urandom_range(0, 3))
							0:       r.iv = 64'h0000_0FFF;
							1:       r.iv = 64'h0000_1000;
							2:       r.iv = 64'h00FF_F000;
							default: r.iv = 64'h0100_0000;
						endcase
					end
					7:       r.iv = -64'($urandom_range(1, 4096));
					default: ;
				endcase
			end
			CMD_LDST: begin
				sc = (r.aw == AW_BYTE) ? 0 : (r.aw == AW_HALF) ? 1 : (r.wd ? 3 : 2);
				case (pick)
					0, 1, 2, 3, 4, 5: r.iv = 64'($urandom_range(0, 4095)) << sc;
					6: r.iv = (64'($urandom_range(0, 4095)) << sc) | 64'($urandom_range(1, 7));
					7: r.iv = 64'($urandom_range(4095, 4200)) << sc;
					8: r.iv = -64'($urandom_range(1, 64));
					default: ;
				endcase
			end
			default: ;
		endcase
		return r;
	endfunction

	// Pin the interesting fields of a random instruction; when rel is set the
	// immediate is a distance from pc rather than an absolute target.
	function automatic insn_req_t directed(cmd_t c, logic ureg, logic [63:0] v, logic rel,
			logic wd, logic [1:0] aw);
		insn_req_t r;
		r = random_insn();
		r.cmd     = c;
		r.use_reg = ureg;
		r.iv      = rel ? r.pcv + v : v;
		r.wd      = wd;
		r.aw      = aw;
		return r;
	endfunction

	// Present one request at the falling edge, optionally after an idle burst,
	// and hold it until the block takes it. Returns at the accepting edge.
	task automatic offer(input insn_req_t r);
		int unsigned gap;
		@(negedge clk);
		if (!drain_phase && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			gap = $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		cmd           <= r.cmd;
		use_reg       <= r.use_reg;
		reg_d         <= r.rd;
		reg_n         <= r.rn;
		reg_m         <= r.rm;
		wide          <= r.wd;
		cond          <= r.cc;
		shift_quarter <= r.hw;
		imm           <= r.iv;
		pc            <= r.pcv;
		load          <= r.ld;
		access_width  <= r.aw;
		do
			@(posedge clk);
		while (!in_ready);
		requests_sent++;
	endtask

	// Sender: reset, directed requests, random requests, drain, verdict.
	initial begin
		int n;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		cmd           = CMD_NOP;
		use_reg       = 1'b0;
		reg_d         = '0;
		reg_n         = '0;
		reg_m         = '0;
		wide          = 1'b0;
		cond          = '0;
		shift_quarter = '0;
		imm           = '0;
		pc            = '0;
		load          = 1'b0;
		access_width  = AW_BYTE;
		drain_phase   = 1'b0;
		gap_odds      = 0;
		requests_sent = 0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// fixed encodings, register branches and immediate-only forms at their field extremes
		offer(directed(CMD_NOP, 1'b0, 64'h0, 1'b0, 1'b0, AW_BYTE));
		offer(directed(CMD_RET, 1'b0, 64'h0, 1'b0, 1'b1, AW_BYTE));
		offer(directed(CMD_BRK, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, AW_BYTE));
		offer(directed(CMD_SVC, 1'b0, 64'hFFFF_FFFF_FFFF_0000, 1'b0, 1'b0, AW_BYTE));
		offer(directed(CMD_BR, 1'b0, 64'h0, 1'b0, 1'b0, AW_BYTE));
		offer(directed(CMD_BLR, 1'b0, 64'h0, 1'b0, 1'b1, AW_BYTE));
		// branch distances: backward, largest forward, most negative, wrap-around
		offer(directed(CMD_B, 1'b0, -64'sd4, 1'b1, 1'b0, AW_BYTE));
		offer(directed(CMD_BL, 1'b0, 64'h07FF_FFFC, 1'b1, 1'b0, AW_BYTE));
		offer(directed(CMD_BCOND, 1'b0, -64'sd1048576, 1'b1, 1'b0, AW_BYTE));
		offer(directed(CMD_CBZ, 1'b0, 64'h0003_FFFC, 1'b1, 1'b0, AW_BYTE));
		offer(directed(CMD_CBNZ, 1'b0, 64'h8000_0000_0000_0008, 1'b1, 1'b1, AW_BYTE));
		// moves: register form, 32-bit truncation, overflow, negative
		offer(directed(CMD_MOV, 1'b1, 64'h0, 1'b0, 1'b1, AW_BYTE));
		offer(directed(CMD_MOV, 1'b0, 64'hFFFF_FFFF, 1'b0, 1'b0, AW_BYTE));
		offer(directed(CMD_MOV, 1'b0, 64'h1_0000_0000, 1'b0, 1'b1, AW_BYTE));
		offer(directed(CMD_MOVZ, 1'b0, 64'hFFFF, 1'b0, 1'b0, AW_BYTE));
		offer(directed(CMD_MOVK, 1'b0, 64'h1_0000, 1'b0, 1'b1, AW_BYTE));
		offer(directed(CMD_MOVN, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, AW_BYTE));
		// arithmetic: plain and shifted immediates, out-of-range compare, registers
		offer(directed(CMD_ADD, 1'b0, 64'hFFF, 1'b0, 1'b1, AW_BYTE));
		offer(directed(CMD_SUB, 1'b0, 64'hFF_F000, 1'b0, 1'b0, AW_BYTE));
		offer(directed(CMD_CMP, 1'b0, 64'h1001, 1'b0, 1'b1, AW_BYTE));
		offer(directed(CMD_ADD, 1'b1, 64'h0, 1'b0, 1'b0, AW_BYTE));
		offer(directed(CMD_CMP, 1'b1, 64'h0, 1'b0, 1'b1, AW_BYTE));
		// loads and stores at the top of the offset range, and one past it
		offer(directed(CMD_LDST, 1'b0, 64'd4095, 1'b0, 1'b0, AW_BYTE));
		offer(directed(CMD_LDST, 1'b0, 64'd32760, 1'b0, 1'b1, AW_REG));
		offer(directed(CMD_LDST, 1'b0, 64'd16384, 1'b0, 1'b0, AW_ALT));
		offer(directed(CMD_WORD, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, AW_BYTE));
		offer(directed(CMD_TOP_CODE, 1'b0, 64'h0, 1'b0, 1'b0, AW_BYTE));

		// random part; sender gap density changes every hundred requests
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0)
				gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 8);
			if (n == RANDOM_ITEMS - DRAIN_ITEMS)
				drain_phase = 1'b1;
			offer(random_insn());
		end

		@(negedge clk);
		in_valid <= 1'b0;

		// drop out once no prediction is left pending, then allow the tail
		do
			@(posedge clk);
		while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Encoded %0d requests over all twenty forms plus undefined codes,",
			requests_sent);
		$display("with every status path exercised; %0d results compared.", results_seen);
		if (fail_count == 0)
			$display("arm64_instruction_encoder_unit: match");
		else
			$display("arm64_instruction_encoder_unit: mismatch");
		$finish;
	end

	// Receiver: random stall bursts in choppy stretches, calm stretches with
	// no stalls, two long hold-offs to back the block up into its input, and
	// a steady ready during the drain.
	initial begin
		int unsigned stall_left;
		int unsigned stretch_left;
		int unsigned tick;
		bit          choppy;
		out_ready    = 1'b0;
		stall_left   = 0;
		stretch_left = 0;
		tick         = 0;
		choppy       = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			tick++;
			if ((tick == 150 || tick == 1200) && !drain_phase) begin
				// hold off while the sender keeps offering
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (drain_phase) begin
				out_ready <= 1'b1;
			end else begin
				if (stretch_left == 0) begin
					choppy       = ($urandom_range(0, 2) != 0);
					stretch_left = $urandom_range(40, 160);
				end
				stretch_left--;
				if (stall_left != 0) begin
					out_ready <= 1'b0;
					stall_left--;
				end else begin
					out_ready <= 1'b1;
					if (choppy && $urandom_range(0, 5) == 0)
						stall_left = $urandom_range(1, 16);
				end
			end
		end
	end

	// Watchdog: count cycles in which neither channel moves a request.
	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
		$display("arm64_instruction_encoder_unit: mismatch");
		$finish;
	end

endmodule
